### hw/rtl/rbis_pkg.sv
`default_nettype none
package rbis_pkg;

  localparam int BODY_COUNT = 64;
  localparam int ADDR_W     = $clog2(BODY_COUNT);

  // speed below 0.1 in raw Q16.16 units, and its square
  localparam logic [12:0] SLOW_LIMIT = 13'd6554;
  localparam logic [26:0] SLOW_SQ    = 27'd42954916;

  localparam logic [30:0] SIM_SPEED_RESET = 31'd65536;
  localparam logic [17:0] ONE_Q16         = 18'd65536;

  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 33;

  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_TICK    = 2'd1;
  localparam logic [1:0] FN_COLLIDE = 2'd2;

  localparam logic [1:0] CFG_GRAVITY_X = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_Y = 2'd1;
  localparam logic [1:0] CFG_SIM_SPEED = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        mass;
    logic [16:0]        bounce;
    logic               is_static;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_A,
    ST_CAP_A,
    ST_CAP_B,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV_J,
    ST_WR_A,
    ST_WR_B
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/rbis_ram.sv
`default_nettype none
module rbis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### hw/rtl/rbis_div.sv
`default_nettype none
module rbis_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rbis_pkg::div_req_t  req,
  output rbis_pkg::div_rsp_t       rsp
);
  import rbis_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_D_W:0]   rem;
  logic [DIV_N_W-1:0] quo;
  logic [DIV_D_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               active;
  logic               done;
  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem[DIV_D_W-1:0], quo[DIV_N_W-1]};
    ge      = shifted >= {1'b0, dvs};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
      end else if (active && cnt == CNT_W'(DIV_N_W - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= '0;
    end else if (active) begin
      rem <= ge ? trial : shifted;
      quo <= {quo[DIV_N_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

### hw/rtl/rigid_body_impulse_step_core.sv
`default_nettype none
// Table of 2D rigid bodies in Q16.16 held in one synchronous RAM. An item is
// taken when start is high and busy is low; busy stays high until its last
// result is issued. Results appear for exactly one cycle with strobe high and
// cannot be held off. A load writes the table in ST_LOAD and reports from
// the result registers. A tick reads body_a (ST_RD_A, ST_CAP_A), checks it,
// runs ten products through the one shared 33x33 multiplier (ST_MUL, then
// ST_ACC for each), then writes back; a static or slow body skips the
// products. A collide reads both bodies, runs nine products and three
// divisions (two inverse masses and the impulse) on a shared restoring
// divider that retires one quotient bit per cycle, 48 bits a division. A slow
// body_a skips the products and divisions, and a separating pair stops after
// the normal velocity. The two results come on consecutive cycles, body_a
// first, and last marks the final result of every item. Configuration writes
// are always taken (cfg_ready is tied high) and belong in idle periods.
module rigid_body_impulse_step_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [5:0]         body_a,
  input  wire logic [5:0]         body_b,
  input  wire logic signed [31:0] vec_x,
  input  wire logic signed [31:0] vec_y,
  input  wire logic signed [31:0] load_vel_x,
  input  wire logic signed [31:0] load_vel_y,
  input  wire logic [30:0]        load_mass,
  input  wire logic [16:0]        load_bounce,
  input  wire logic               load_static,
  input  wire logic [30:0]        delta_time,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    strobe,
  output logic [5:0]              body,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic                    changed,
  output logic                    last
);
  import rbis_pkg::*;

  // tick product sequence
  localparam logic [3:0] TK_VX_DT = 4'd0;
  localparam logic [3:0] TK_PX    = 4'd1;
  localparam logic [3:0] TK_VY_DT = 4'd2;
  localparam logic [3:0] TK_PY    = 4'd3;
  localparam logic [3:0] TK_GX_DT = 4'd4;
  localparam logic [3:0] TK_GX_M  = 4'd5;
  localparam logic [3:0] TK_VX    = 4'd6;
  localparam logic [3:0] TK_GY_DT = 4'd7;
  localparam logic [3:0] TK_GY_M  = 4'd8;
  localparam logic [3:0] TK_VY    = 4'd9;
  // collide product sequence
  localparam logic [3:0] CL_RXN   = 4'd0;
  localparam logic [3:0] CL_VN    = 4'd1;
  localparam logic [3:0] CL_J     = 4'd2;
  localparam logic [3:0] CL_IX    = 4'd3;
  localparam logic [3:0] CL_IY    = 4'd4;
  localparam logic [3:0] CL_VAX   = 4'd5;
  localparam logic [3:0] CL_VAY   = 4'd6;
  localparam logic [3:0] CL_VBX   = 4'd7;
  localparam logic [3:0] CL_VBY   = 4'd8;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic [30:0]        U31_MAX = 31'h7fff_ffff;
  localparam logic [DIV_N_W-1:0] TWO_POW_32 = DIV_N_W'(64'h1_0000_0000);

  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v[49:31] == '0 || v[49:31] == '1) r = v[31:0];
    else r = v[49] ? S32_MIN : S32_MAX;
    return r;
  endfunction

  function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v[50:31] == '0 || v[50:31] == '1) r = v[31:0];
    else r = v[50] ? S32_MIN : S32_MAX;
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? S32_MIN : S32_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) r = s[32] ? S32_MIN : S32_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic [30:0] sat_quo(input logic [DIV_N_W-1:0] q);
    return (q[DIV_N_W-1:31] != '0) ? U31_MAX : q[30:0];
  endfunction

  function automatic logic signed [32:0] s33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [32:0] u33(input logic [30:0] v);
    return {2'b00, v};
  endfunction

  state_t state, state_next;

  // configuration
  logic signed [31:0] gravity_x, gravity_y;
  logic [30:0]        sim_speed;

  // captured item
  logic [1:0]         func_r;
  logic [5:0]         a_in, b_in;
  body_t              in_rec;
  logic [30:0]        dt;

  // working values
  body_t              rec_a, rec_b;
  logic signed [31:0] npx, npy, nvx, nvy, nvbx, nvby;
  logic signed [31:0] rx, ry, vn, t0, j, jq, ix, iy;
  logic signed [49:0] acc;
  logic [30:0]        ia, ib;
  logic [3:0]         step;
  logic signed [65:0] prod;

  // RAM port
  logic               mem_we;
  logic               mem_sel_b;
  logic [ADDR_W-1:0]  mem_addr;
  body_t              mem_wdata;
  logic [BODY_W-1:0]  mem_rdata;
  body_t              rd_rec;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               accept;
  logic               in_range;
  logic [11:0]        a_wide, b_wide;
  logic [ADDR_W-1:0]  a_addr, b_addr;
  logic               emit_load, emit_a, emit_b;

  logic signed [32:0] mx, my;
  logic signed [49:0] fl;
  logic signed [31:0] qm;
  logic signed [31:0] vn_next;
  logic signed [32:0] neg_vn;
  logic [16:0]        e_min;
  logic [32:0]        abs_x, abs_y;
  logic [26:0]        sq_sum;
  logic               slow;
  logic [30:0]        ib_now;

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign in_range = ({7'd0, body_a} < 13'(BODY_COUNT)) &&
                    (func != FN_COLLIDE || {7'd0, body_b} < 13'(BODY_COUNT));

  // body indices widened to 12 bits so that table depths up to 4096 address correctly
  assign a_wide = {6'd0, a_in};
  assign b_wide = {6'd0, b_in};
  assign a_addr = a_wide[ADDR_W-1:0];
  assign b_addr = b_wide[ADDR_W-1:0];
  assign rd_rec = body_t'(mem_rdata);

  // product in Q16.16: floor by arithmetic shift, then clamp
  assign fl      = prod[65:16];
  assign qm      = sat50(fl);
  assign vn_next = sat51({fl[49], fl} + {acc[49], acc});
  assign neg_vn  = 33'sd0 - s33(vn);
  assign e_min   = (rec_a.bounce < rec_b.bounce) ? rec_a.bounce : rec_b.bounce;
  assign ib_now  = sat_quo(div_rsp.quotient);

  // slow test on body_a's velocity: either axis at the limit is never slow
  always_comb begin
    abs_x  = rec_a.vel_x[31] ? 33'd0 - {1'b1, rec_a.vel_x} : {1'b0, rec_a.vel_x};
    abs_y  = rec_a.vel_y[31] ? 33'd0 - {1'b1, rec_a.vel_y} : {1'b0, rec_a.vel_y};
    sq_sum = 27'({14'd0, abs_x[12:0]} * {14'd0, abs_x[12:0]}) +
             27'({14'd0, abs_y[12:0]} * {14'd0, abs_y[12:0]});
    slow   = (abs_x < {20'd0, SLOW_LIMIT}) && (abs_y < {20'd0, SLOW_LIMIT}) &&
             (sq_sum < SLOW_SQ);
  end

  // multiplier operand select
  always_comb begin
    mx = '0;
    my = '0;
    if (func_r == FN_TICK) begin
      case (step)
        TK_VX_DT: begin mx = s33(rec_a.vel_x); my = u33(dt); end
        TK_VY_DT: begin mx = s33(rec_a.vel_y); my = u33(dt); end
        TK_GX_DT: begin mx = s33(gravity_x);   my = u33(dt); end
        TK_GY_DT: begin mx = s33(gravity_y);   my = u33(dt); end
        TK_GX_M, TK_GY_M: begin mx = s33(t0); my = u33(rec_a.mass); end
        default: begin mx = s33(t0); my = u33(sim_speed); end
      endcase
    end else begin
      case (step)
        CL_RXN: begin mx = s33(rx); my = s33(in_rec.pos_x); end
        CL_VN:  begin mx = s33(ry); my = s33(in_rec.pos_y); end
        CL_J:   begin mx = {15'd0, ONE_Q16 + {1'b0, e_min}}; my = neg_vn; end
        CL_IX:  begin mx = s33(jq); my = s33(in_rec.pos_x); end
        CL_IY:  begin mx = s33(jq); my = s33(in_rec.pos_y); end
        CL_VAX: begin mx = u33(ia); my = s33(ix); end
        CL_VAY: begin mx = u33(ia); my = s33(iy); end
        CL_VBX: begin mx = u33(ib); my = s33(ix); end
        default: begin mx = u33(ib); my = s33(iy); end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_range) begin
          if (func == FN_LOAD) state_next = ST_LOAD;
          else if (func == FN_TICK || func == FN_COLLIDE) state_next = ST_RD_A;
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_RD_A:  state_next = ST_CAP_A;
      ST_CAP_A: state_next = (func_r == FN_COLLIDE) ? ST_CAP_B : ST_CHECK;
      ST_CAP_B: state_next = ST_CHECK;
      ST_CHECK: begin
        if (func_r == FN_TICK && (rec_a.is_static || slow)) state_next = ST_WR_A;
        else if (func_r == FN_COLLIDE && slow) state_next = ST_WR_A;
        else state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        if (func_r == FN_TICK) begin
          state_next = (step == TK_VY) ? ST_WR_A : ST_MUL;
        end else if (step == CL_VN && !vn_next[31] && vn_next != '0) begin
          state_next = ST_WR_A;
        end else if (step == CL_J) begin
          state_next = ST_DIV_A;
        end else if (step == CL_VBY) begin
          state_next = ST_WR_A;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DIV_A: if (div_rsp.done) state_next = ST_DIV_B;
      ST_DIV_B: if (div_rsp.done) state_next = ST_DIV_J;
      ST_DIV_J: if (div_rsp.done) state_next = ST_MUL;
      ST_WR_A:  state_next = (func_r == FN_COLLIDE) ? ST_WR_B : ST_IDLE;
      ST_WR_B:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we           = 1'b0;
    mem_sel_b        = 1'b0;
    emit_load        = 1'b0;
    emit_a           = 1'b0;
    emit_b           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = TWO_POW_32;
    div_req.divisor  = {2'b00, rec_a.mass};
    unique case (state)
      ST_LOAD: begin
        mem_we    = 1'b1;
        emit_load = 1'b1;
      end
      ST_CAP_A: mem_sel_b = 1'b1;
      ST_ACC: div_req.start = (func_r == FN_COLLIDE) && (step == CL_J);
      ST_DIV_A: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = {2'b00, rec_b.mass};
      end
      ST_DIV_B: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {j[31:0], 16'h0000};
        div_req.divisor  = {2'b00, ia} + {2'b00, ib_now};
      end
      ST_WR_A: begin
        mem_we = 1'b1;
        emit_a = 1'b1;
      end
      ST_WR_B: begin
        mem_we    = 1'b1;
        mem_sel_b = 1'b1;
        emit_b    = 1'b1;
      end
      default: ;
    endcase
  end

  assign mem_addr = mem_sel_b ? b_addr : a_addr;

  always_comb begin
    mem_wdata = rec_a;
    if (state == ST_LOAD) begin
      mem_wdata = in_rec;
    end else if (state == ST_WR_B) begin
      mem_wdata       = rec_b;
      mem_wdata.vel_x = nvbx;
      mem_wdata.vel_y = nvby;
    end else begin
      mem_wdata.pos_x = npx;
      mem_wdata.pos_y = npy;
      mem_wdata.vel_x = nvx;
      mem_wdata.vel_y = nvy;
    end
  end

  rbis_ram #(
    .WIDTH(BODY_W),
    .DEPTH(BODY_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  rbis_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      gravity_x <= '0;
      gravity_y <= '0;
      sim_speed <= SIM_SPEED_RESET;
    end else begin
      state  <= state_next;
      strobe <= emit_load || emit_a || emit_b;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRAVITY_X: gravity_x <= cfg_data;
          CFG_GRAVITY_Y: gravity_y <= cfg_data;
          CFG_SIM_SPEED: sim_speed <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // capture the item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r           <= func;
      a_in             <= body_a;
      b_in             <= body_b;
      dt               <= delta_time;
      in_rec.pos_x     <= vec_x;
      in_rec.pos_y     <= vec_y;
      in_rec.vel_x     <= load_vel_x;
      in_rec.vel_y     <= load_vel_y;
      in_rec.mass      <= load_mass;
      in_rec.bounce    <= load_bounce;
      in_rec.is_static <= load_static;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_MUL) prod <= mx * my;
    case (state)
      ST_CAP_A: rec_a <= rd_rec;
      ST_CAP_B: rec_b <= rd_rec;
      ST_CHECK: begin
        npx  <= rec_a.pos_x;
        npy  <= rec_a.pos_y;
        nvx  <= (func_r == FN_TICK && rec_a.is_static) ? '0 : rec_a.vel_x;
        nvy  <= (func_r == FN_TICK && rec_a.is_static) ? '0 : rec_a.vel_y;
        nvbx <= rec_b.vel_x;
        nvby <= rec_b.vel_y;
        rx   <= sat_sub(rec_b.vel_x, rec_a.vel_x);
        ry   <= sat_sub(rec_b.vel_y, rec_a.vel_y);
        step <= '0;
      end
      ST_ACC: begin
        step <= step + 4'd1;
        if (func_r == FN_TICK) begin
          case (step)
            TK_PX: npx <= sat_add(rec_a.pos_x, qm);
            TK_PY: npy <= sat_add(rec_a.pos_y, qm);
            TK_VX: nvx <= sat_add(rec_a.vel_x, qm);
            TK_VY: nvy <= sat_add(rec_a.vel_y, qm);
            default: t0 <= qm;
          endcase
        end else begin
          case (step)
            CL_RXN: acc  <= fl;
            CL_VN:  vn   <= vn_next;
            CL_J:   j    <= qm;
            CL_IX:  ix   <= qm;
            CL_IY:  iy   <= qm;
            CL_VAX: nvx  <= sat_sub(rec_a.vel_x, qm);
            CL_VAY: nvy  <= sat_sub(rec_a.vel_y, qm);
            CL_VBX: nvbx <= sat_add(rec_b.vel_x, qm);
            default: nvby <= sat_add(rec_b.vel_y, qm);
          endcase
        end
      end
      ST_DIV_A: if (div_rsp.done) ia <= ib_now;
      ST_DIV_B: if (div_rsp.done) ib <= ib_now;
      ST_DIV_J: if (div_rsp.done) jq <= {1'b0, ib_now};
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (emit_load) begin
      body    <= a_in;
      pos_x   <= in_rec.pos_x;
      pos_y   <= in_rec.pos_y;
      vel_x   <= in_rec.vel_x;
      vel_y   <= in_rec.vel_y;
      changed <= 1'b1;
      last    <= 1'b1;
    end else if (emit_a) begin
      body    <= a_in;
      pos_x   <= npx;
      pos_y   <= npy;
      vel_x   <= nvx;
      vel_y   <= nvy;
      changed <= (npx != rec_a.pos_x) || (npy != rec_a.pos_y) ||
                 (nvx != rec_a.vel_x) || (nvy != rec_a.vel_y);
      last    <= func_r == FN_TICK;
    end else if (emit_b) begin
      body    <= b_in;
      pos_x   <= rec_b.pos_x;
      pos_y   <= rec_b.pos_y;
      vel_x   <= nvbx;
      vel_y   <= nvby;
      changed <= (nvbx != rec_b.vel_x) || (nvby != rec_b.vel_y);
      last    <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rbis_checker.sv
`default_nettype none
module rbis_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] func,
  input wire logic [5:0] body_a,
  input wire logic       strobe,
  input wire logic       changed,
  input wire logic       last
);
  import rbis_pkg::*;

  // a load stays busy in ST_LOAD, then reports its body as a final changed result
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FN_LOAD && ({7'd0, body_a} < 13'(BODY_COUNT))
    |=> busy ##1 (strobe && last && changed))
    else $error("load result missing");

  // the first collide result is followed at once by the final one
  a_pair: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && last)
    else $error("second collide result missing");

  // the final result leaves the block free for the next item
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy after final result");

  // no result can appear in the first busy cycle of an item
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !strobe)
    else $error("result at item start");

endmodule

bind rigid_body_impulse_step_core rbis_checker u_rbis_checker (.*);
`default_nettype wire

### sim/rigid_body_impulse_step_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_impulse_step_core_tb;
  import rbis_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         body_a;
    logic [5:0]         body_b;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic [30:0]        load_mass;
    logic [16:0]        load_bounce;
    logic               load_static;
    logic [30:0]        delta_time;
  } step_cmd_t;

  typedef struct packed {
    logic [5:0]         body;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               changed;
    logic               last;
  } body_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = '0;
  logic [5:0] body_a = '0;
  logic [5:0] body_b = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] load_vel_x = '0;
  logic signed [31:0] load_vel_y = '0;
  logic [30:0] load_mass = '0;
  logic [16:0] load_bounce = '0;
  logic load_static = 1'b0;
  logic [30:0] delta_time = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic strobe;
  logic [5:0] body;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic changed, last;

  rigid_body_impulse_step_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .body_a(body_a), .body_b(body_b), .vec_x(vec_x), .vec_y(vec_y),
    .load_vel_x(load_vel_x), .load_vel_y(load_vel_y), .load_mass(load_mass),
    .load_bounce(load_bounce), .load_static(load_static), .delta_time(delta_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .body(body), .pos_x(pos_x),
    .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y), .changed(changed), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the body table and the registers, kept by the predictor.
  logic signed [31:0] sh_px [BODY_COUNT];
  logic signed [31:0] sh_py [BODY_COUNT];
  logic signed [31:0] sh_vx [BODY_COUNT];
  logic signed [31:0] sh_vy [BODY_COUNT];
  logic [30:0]        sh_mass [BODY_COUNT];
  logic [16:0]        sh_bounce [BODY_COUNT];
  logic               sh_static [BODY_COUNT];
  bit                 loaded [BODY_COUNT];
  logic signed [31:0] grav_x = '0;
  logic signed [31:0] grav_y = '0;
  logic [30:0]        speed = SIM_SPEED_RESET;

  step_cmd_t    pending_cmds[$];
  step_cmd_t    predict_q[$];
  body_report_t expected_reports[$];
  int  mismatches = 0;
  int  unexpected = 0;
  int  reports_seen = 0;
  int  cmds_sent = 0;
  longint cycles = 0;
  bit  hold_sender = 1'b0;
  bit  transferred = 1'b0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(MAX32)) return MAX32;
    if (v < longint'(MIN32)) return MIN32;
    return v[31:0];
  endfunction

  // Exact product, floored to Q16.16 (arithmetic shift floors), saturated.
  function automatic logic signed [31:0] fix_mul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    p = p >>> 16;
    if (p > 128'sd2147483647) return MAX32;
    if (p < -128'sd2147483648) return MIN32;
    return p[31:0];
  endfunction

  // Either axis at the limit is never slow; this also keeps the sum in range.
  function automatic bit too_slow(logic signed [31:0] vx, logic signed [31:0] vy);
    longint ax, ay;
    ax = vx < 0 ? -longint'(vx) : longint'(vx);
    ay = vy < 0 ? -longint'(vy) : longint'(vy);
    if (ax >= longint'(SLOW_LIMIT) || ay >= longint'(SLOW_LIMIT)) return 1'b0;
    return (ax * ax + ay * ay) < longint'(SLOW_SQ);
  endfunction

  function automatic longint recip_mass(logic [30:0] m);
    longint q;
    if (m == 0) return longint'(MAX32);
    q = 64'd4294967296 / longint'(m);
    return q > longint'(MAX32) ? longint'(MAX32) : q;
  endfunction

  function automatic body_report_t report_of(int i, bit chg, bit fin);
    body_report_t r;
    r.body = i[5:0];
    r.pos_x = sh_px[i]; r.pos_y = sh_py[i];
    r.vel_x = sh_vx[i]; r.vel_y = sh_vy[i];
    r.changed = chg; r.last = fin;
    return r;
  endfunction

  // Advance the shadow table by one command and queue its reports.
  task automatic predict_step(step_cmd_t c);
    int a, b;
    logic signed [31:0] px, py, vx, vy, vax, vay, vbx, vby, rx, ry, vn, jq, ix, iy;
    longint dt, m, ia, ib, j, sum;
    logic [16:0] e;
    bit ch, cha, chb;
    a = c.body_a; b = c.body_b;
    cha = 0; chb = 0;
    case (c.func)
      FN_LOAD: begin
        sh_px[a] = c.vec_x; sh_py[a] = c.vec_y;
        sh_vx[a] = c.load_vel_x; sh_vy[a] = c.load_vel_y;
        sh_mass[a] = c.load_mass; sh_bounce[a] = c.load_bounce;
        sh_static[a] = c.load_static;
        expected_reports.push_back(report_of(a, 1, 1));
      end
      FN_TICK: begin
        dt = c.delta_time; m = sh_mass[a];
        px = sh_px[a]; py = sh_py[a]; vx = sh_vx[a]; vy = sh_vy[a];
        if (sh_static[a]) begin
          sh_vx[a] = '0; sh_vy[a] = '0;
        end else if (!too_slow(vx, vy)) begin
          sh_px[a] = sat32(longint'(px) + fix_mul(fix_mul(vx, dt), speed));
          sh_py[a] = sat32(longint'(py) + fix_mul(fix_mul(vy, dt), speed));
          sh_vx[a] = sat32(longint'(vx) +
                           fix_mul(fix_mul(fix_mul(grav_x, dt), m), speed));
          sh_vy[a] = sat32(longint'(vy) +
                           fix_mul(fix_mul(fix_mul(grav_y, dt), m), speed));
        end
        ch = px != sh_px[a] || py != sh_py[a] || vx != sh_vx[a] || vy != sh_vy[a];
        expected_reports.push_back(report_of(a, ch, 1));
      end
      FN_COLLIDE: begin
        vax = sh_vx[a]; vay = sh_vy[a]; vbx = sh_vx[b]; vby = sh_vy[b];
        if (!too_slow(vax, vay)) begin
          rx = sat32(longint'(vbx) - vax);
          ry = sat32(longint'(vby) - vay);
          vn = sat32((longint'(rx) * c.vec_x >>> 16) + (longint'(ry) * c.vec_y >>> 16));
          if (vn <= 0) begin
            e = sh_bounce[a] < sh_bounce[b] ? sh_bounce[a] : sh_bounce[b];
            j = fix_mul(65536 + longint'(e), -longint'(vn));
            ia = recip_mass(sh_mass[a]);
            ib = recip_mass(sh_mass[b]);
            sum = ia + ib;
            jq = sat32((j * 65536) / sum); // truncates toward zero
            ix = fix_mul(jq, c.vec_x);
            iy = fix_mul(jq, c.vec_y);
            sh_vx[a] = sat32(longint'(vax) - fix_mul(ia, ix));
            sh_vy[a] = sat32(longint'(vay) - fix_mul(ia, iy));
            vbx = sh_vx[b]; vby = sh_vy[b];
            sh_vx[b] = sat32(longint'(vbx) + fix_mul(ib, ix));
            sh_vy[b] = sat32(longint'(vby) + fix_mul(ib, iy));
            cha = vax != sh_vx[a] || vay != sh_vy[a];
            chb = vbx != sh_vx[b] || vby != sh_vy[b];
            if (a == b) begin
              cha = cha || chb;
              chb = cha;
            end
          end
        end
        expected_reports.push_back(report_of(a, cha, 0));
        expected_reports.push_back(report_of(b, chb, 1));
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of transfers with random gaps; predict at each transfer.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || transferred) begin
        if (pending_cmds.size() > 0 && !hold_sender && gap_left == 0) begin
          step_cmd_t c;
          c = pending_cmds.pop_front();
          {func, body_a, body_b, vec_x, vec_y, load_vel_x, load_vel_y, load_mass,
           load_bounce, load_static, delta_time} <= c;
          start <= 1'b1;
          predict_q.push_back(c);
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 60);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // Track transfers at the rising edge.
  always @(posedge clk) begin
    cycles++;
    transferred = start && !busy && !rst;
    if (transferred) begin
      predict_step(predict_q.pop_front());
      cmds_sent++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Monitor: every strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      body_report_t got, want;
      got = '{body, pos_x, pos_y, vel_x, vel_y, changed, last};
      reports_seen++;
      if (expected_reports.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result: body %0d", body);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: exp body %0d p(%0d,%0d) v(%0d,%0d) ch %0d l %0d / got body %0d p(%0d,%0d) v(%0d,%0d) ch %0d l %0d",
                     want.body, want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                     want.changed, want.last, got.body, got.pos_x, got.pos_y,
                     got.vel_x, got.vel_y, got.changed, got.last);
        end
      end
    end
  end

  function automatic step_cmd_t make_cmd(logic [1:0] f, int a, int b);
    step_cmd_t c;
    c.func = f; c.body_a = 6'(a); c.body_b = 6'(b);
    c.vec_x = $urandom; c.vec_y = $urandom;
    c.load_vel_x = $urandom; c.load_vel_y = $urandom;
    c.load_mass = 31'($urandom_range(1, 32'h7fffffff));
    c.load_bounce = 17'($urandom_range(0, 65536));
    c.load_static = 1'($urandom_range(0, 1));
    c.delta_time = 31'($urandom);
    return c;
  endfunction

  // Random command on loaded bodies, values mostly in a physical range.
  function automatic step_cmd_t random_cmd();
    step_cmd_t c;
    int a, b, pick;
    pick = $urandom_range(0, 9);
    do a = $urandom_range(0, BODY_COUNT - 1); while (!loaded[a]);
    do b = $urandom_range(0, BODY_COUNT - 1); while (!loaded[b]);
    if (pick < 2) begin
      // a load may target any body, which widens the set of loaded bodies
      a = $urandom_range(0, BODY_COUNT - 1);
      c = make_cmd(FN_LOAD, a, 0);
      if ($urandom_range(0, 3) != 0) begin
        c.vec_x = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        c.vec_y = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        c.load_vel_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        c.load_vel_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        c.load_mass = 31'($urandom_range(1 << 12, 1 << 20));
        c.load_static = $urandom_range(0, 5) == 0;
      end
    end else if (pick < 6) begin
      c = make_cmd(FN_TICK, a, b);
      if ($urandom_range(0, 3) != 0) c.delta_time = 31'($urandom_range(0, 1 << 16));
    end else begin
      c = make_cmd(FN_COLLIDE, a, b);
      if ($urandom_range(0, 3) != 0) begin
        c.vec_x = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        c.vec_y = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      end
    end
    if (c.func == FN_LOAD) loaded[a] = 1;
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRAVITY_X: grav_x = val;
      CFG_GRAVITY_Y: grav_y = val;
      default: speed = val[30:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain everything queued, then allow the block to settle.
  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_cmds.size() > 0 || predict_q.size() > 0 || start ||
            expected_reports.size() > 0 || busy) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    step_cmd_t c;
    int phase, n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of every field, each operation and special case.
    c = make_cmd(FN_LOAD, 0, 0);
    c.vec_x = MAX32; c.vec_y = MIN32; c.load_vel_x = MAX32; c.load_vel_y = MIN32;
    c.load_mass = 31'h7fffffff; c.load_bounce = 17'd65536; c.load_static = 0;
    c.delta_time = 31'h7fffffff;
    pending_cmds.push_back(c);
    c = make_cmd(FN_LOAD, 63, 0);
    c.vec_x = 0; c.vec_y = 0; c.load_vel_x = 100; c.load_vel_y = -100;
    c.load_mass = 1; c.load_bounce = 0; c.load_static = 0;
    pending_cmds.push_back(c);
    c = make_cmd(FN_LOAD, 1, 0);
    c.load_vel_x = 32'h00030000; c.load_vel_y = -32'sh00020000;
    c.load_mass = 31'h10000; c.load_bounce = 17'h8000; c.load_static = 1;
    pending_cmds.push_back(c);
    c = make_cmd(FN_LOAD, 2, 0);
    c.load_vel_x = -32'sh00050000; c.load_vel_y = 32'h00010000;
    c.load_mass = 31'h20000; c.load_bounce = 17'h4000; c.load_static = 0;
    pending_cmds.push_back(c);
    foreach (loaded[i]) loaded[i] = (i <= 2 || i == 63);
    c = make_cmd(FN_TICK, 63, 0); c.delta_time = 31'h10000;  // slow body
    pending_cmds.push_back(c);
    c = make_cmd(FN_TICK, 1, 0); pending_cmds.push_back(c);    // static body
    c = make_cmd(FN_TICK, 0, 0); c.delta_time = 31'h7fffffff;   // saturation
    pending_cmds.push_back(c);
    c = make_cmd(FN_TICK, 2, 0); c.delta_time = 0; pending_cmds.push_back(c);
    c = make_cmd(FN_COLLIDE, 63, 2); pending_cmds.push_back(c);  // slow a
    c = make_cmd(FN_COLLIDE, 2, 1); c.vec_x = 32'h10000; c.vec_y = 0;
    pending_cmds.push_back(c);                                   // separating
    c = make_cmd(FN_COLLIDE, 2, 1); c.vec_x = -32'sh10000; c.vec_y = 0;
    pending_cmds.push_back(c);                                   // approaching
    c = make_cmd(FN_COLLIDE, 2, 2); c.vec_x = 32'h10000; c.vec_y = 32'h10000;
    pending_cmds.push_back(c);                                   // same body
    c = make_cmd(FN_COLLIDE, 0, 63); c.vec_x = MIN32; c.vec_y = MAX32;
    pending_cmds.push_back(c);
    drain();

    // Random phases over several register settings, extremes among them.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CFG_GRAVITY_X, 0); write_reg(CFG_GRAVITY_Y, -32'sh9cccc); end
        1: begin write_reg(CFG_GRAVITY_X, MAX32); write_reg(CFG_GRAVITY_Y, MIN32);
                 write_reg(CFG_SIM_SPEED, 32'h7fffffff); end
        2: begin write_reg(CFG_SIM_SPEED, 0); end
        3: begin write_reg(CFG_GRAVITY_X, $urandom_range(0, 1 << 12));
                 write_reg(CFG_GRAVITY_Y, -$urandom_range(0, 1 << 14));
                 write_reg(CFG_SIM_SPEED, $urandom_range(1 << 14, 1 << 17)); end
        default: begin write_reg(CFG_GRAVITY_X, $urandom); write_reg(CFG_GRAVITY_Y, $urandom);
                 write_reg(CFG_SIM_SPEED, $urandom); end
      endcase
      for (n = 0; n < 88; n++) begin
        pending_cmds.push_back(random_cmd());
        // hold the sender once until every expected result is back
        if (phase == 2 && n == 40) begin
          while (pending_cmds.size() > 0 || predict_q.size() > 0 || start)
            @(posedge clk);
          hold_sender = 1'b1;
          while (expected_reports.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    $display("covered %0d commands and %0d checked results over 5 register settings",
             cmds_sent, reports_seen);
    $display("load, tick and collide exercised with static, slow, separating and saturated cases");
    if (mismatches == 0 && unexpected == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
               expected_reports.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
